### rtl/chol_pkg.sv
// Shared types and constants of the Cholesky factorizer.
package chol_pkg;

  localparam int MAX_N    = 16;
  localparam int IDX_W    = 4;
  localparam int ADDR_W   = 8;
  localparam int DEPTH    = MAX_N * MAX_N;
  localparam int SIZE_W   = 5;
  localparam int ACC_W    = 70;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_FACT  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_NPD = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       value;
  } item_t;

  typedef struct packed {
    logic        start;
    logic        sqrt_mode;
    logic        neg;
    logic [63:0] num;
    logic [31:0] den;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] res;
  } iter_rsp_t;

endpackage

### rtl/chol_front.sv
// Front end: accepts requests, decodes the address and queues them.
module chol_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          action,
  input  logic [3:0]          row,
  input  logic [3:0]          col,
  input  logic signed [31:0]  entry_in,
  output logic                q_valid,
  output chol_pkg::item_t     q_item,
  input  logic                q_pop
);

  chol_pkg::item_t slots [2];
  logic [1:0] count;
  logic       wptr;
  logic       rptr;
  logic       push;
  chol_pkg::item_t incoming;

  always_comb begin
    incoming.action   = action;
    incoming.in_range = ({1'b0, row} < (chol_pkg::IDX_W + 1)'(chol_pkg::MAX_N)) &&
                        ({1'b0, col} < (chol_pkg::IDX_W + 1)'(chol_pkg::MAX_N));
    incoming.addr     = {row, col};
    incoming.value    = entry_in;
  end

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall;
  assign q_valid    = (count != 2'd0);
  assign q_item     = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (q_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### rtl/chol_iter.sv
// Shared iterative unit: restoring divide (one bit a cycle) and square root.
module chol_iter (
  input  logic                clk,
  input  logic                rst,
  input  chol_pkg::iter_req_t req,
  output chol_pkg::iter_rsp_t rsp
);

  logic        busy;
  logic        mode;
  logic        neg;
  logic [5:0]  cnt;
  logic [31:0] den;
  logic [63:0] dnum;
  logic [32:0] drem;
  logic [63:0] sv;
  logic [33:0] sr;
  logic [31:0] sq;
  logic        done;

  logic [32:0] dt;
  logic        dge;
  logic [35:0] tr;
  logic [35:0] trial;
  logic        sge;
  logic [35:0] sdiff;

  always_comb begin
    dt    = {drem[31:0], dnum[63]};
    dge   = dt >= {1'b0, den};
    tr    = {sr, sv[63:62]};
    trial = {2'b00, sq, 2'b01};
    sge   = tr >= trial;
    sdiff = tr - trial;
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.sqrt_mode;
      neg  <= req.neg;
      den  <= req.den;
      dnum <= req.num;
      drem <= '0;
      sv   <= req.num;
      sr   <= '0;
      sq   <= '0;
    end else if (busy) begin
      if (mode) begin
        sr <= sge ? sdiff[33:0] : tr[33:0];
        sq <= {sq[30:0], sge};
        sv <= {sv[61:0], 2'b00};
      end else begin
        drem <= dge ? (dt - {1'b0, den}) : dt;
        dnum <= {dnum[62:0], dge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == (mode ? 6'd31 : 6'd63)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.sat  = 1'b0;
    if (mode) begin
      if (sq[31]) begin
        rsp.sat = 1'b1;
        rsp.res = 32'h7FFF_FFFF;
      end else begin
        rsp.res = sq;
      end
    end else if (neg) begin
      if (dnum > 64'h0000_0000_8000_0000) begin
        rsp.sat = 1'b1;
        rsp.res = 32'h8000_0000;
      end else begin
        rsp.res = -dnum[31:0];
      end
    end else begin
      if (dnum > 64'h0000_0000_7FFF_FFFF) begin
        rsp.sat = 1'b1;
        rsp.res = 32'h7FFF_FFFF;
      end else begin
        rsp.res = dnum[31:0];
      end
    end
  end

endmodule

### rtl/chol_back.sv
// Back end: matrix store, factorization sequencer and result register.
module chol_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     matrix_size_we,
  input  logic [4:0]               matrix_size,
  input  logic                     q_valid,
  input  chol_pkg::item_t          q_item,
  output logic                     q_pop,
  output chol_pkg::iter_req_t      ireq,
  input  chol_pkg::iter_rsp_t      irsp,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [31:0]       entry_out,
  output logic [1:0]               status
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD_INIT = 4'd1;
  localparam logic [3:0] S_INIT    = 4'd2;
  localparam logic [3:0] S_MAC_RD  = 4'd3;
  localparam logic [3:0] S_MAC_MUL = 4'd4;
  localparam logic [3:0] S_MAC_ACC = 4'd5;
  localparam logic [3:0] S_CLAMP   = 4'd6;
  localparam logic [3:0] S_ITER    = 4'd7;
  localparam logic [3:0] S_WB      = 4'd8;
  localparam logic [3:0] S_ZERO    = 4'd9;

  logic [31:0] mem [chol_pkg::DEPTH];
  logic [31:0] rd_a;
  logic [31:0] rd_b;

  logic [3:0]  state;
  logic [4:0]  size;
  logic [4:0]  n;
  logic [4:0]  i;
  logic [4:0]  j;
  logic [4:0]  k;
  logic signed [chol_pkg::ACC_W-1:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] d;
  logic [31:0] res;
  logic        sat;
  logic [1:0]  last_status;

  logic        p_valid;
  logic        p_read;
  logic [1:0]  p_status;
  logic        out_load;
  logic        fact_done;
  logic [1:0]  fact_status;

  logic                       we;
  logic [chol_pkg::ADDR_W-1:0] waddr;
  logic [31:0]                wdata;
  logic [chol_pkg::ADDR_W-1:0] raddr_a;
  logic [chol_pkg::ADDR_W-1:0] raddr_b;
  logic                       re;

  logic        fits;
  logic signed [63:0] rem;

  assign out_load = !result_valid || !result_stall;
  assign q_pop    = (state == S_IDLE) && q_valid && (!p_valid || out_load);

  always_comb begin
    if (size == 5'd0) begin
      n = 5'd1;
    end else if (size > 5'(chol_pkg::MAX_N)) begin
      n = 5'(chol_pkg::MAX_N);
    end else begin
      n = size;
    end
  end

  always_comb begin
    fits = (acc[chol_pkg::ACC_W-1:63] == '0) || (acc[chol_pkg::ACC_W-1:63] == '1);
    if (fits) begin
      rem = acc[63:0];
    end else if (acc[chol_pkg::ACC_W-1]) begin
      rem = 64'sh8000_0000_0000_0000;
    end else begin
      rem = 64'sh7FFF_FFFF_FFFF_FFFF;
    end
  end

  // Memory port selection.
  always_comb begin
    we      = 1'b0;
    waddr   = q_item.addr;
    wdata   = q_item.value;
    re      = 1'b0;
    raddr_a = q_item.addr;
    raddr_b = {j[3:0], k[3:0]};
    unique case (state)
      S_IDLE: begin
        we = q_pop && (q_item.action == chol_pkg::ACT_WRITE) && q_item.in_range;
        re = q_pop && (q_item.action == chol_pkg::ACT_READ);
      end
      S_RD_INIT: begin
        re      = 1'b1;
        raddr_a = {i[3:0], j[3:0]};
        raddr_b = {j[3:0], j[3:0]};
      end
      S_MAC_RD: begin
        re      = 1'b1;
        raddr_a = {i[3:0], k[3:0]};
        raddr_b = {j[3:0], k[3:0]};
      end
      S_WB: begin
        we    = 1'b1;
        waddr = {i[3:0], j[3:0]};
        wdata = res;
      end
      S_ZERO: begin
        we    = (j < n);
        waddr = {i[3:0], j[3:0]};
        wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a <= mem[raddr_a];
      rd_b <= mem[raddr_b];
    end
  end

  always_comb begin
    ireq.start     = 1'b0;
    ireq.sqrt_mode = (j == i);
    ireq.neg       = rem[63];
    ireq.num       = rem[63] ? -rem : rem;
    ireq.den       = d;
    fact_done      = 1'b0;
    fact_status    = sat ? chol_pkg::STAT_SAT : chol_pkg::STAT_OK;
    if (state == S_CLAMP) begin
      if (j < i) begin
        if (d <= 0) begin
          fact_done   = 1'b1;
          fact_status = chol_pkg::STAT_NPD;
        end else begin
          ireq.start = 1'b1;
        end
      end else if (rem <= 0) begin
        fact_done   = 1'b1;
        fact_status = chol_pkg::STAT_NPD;
      end else begin
        ireq.start = 1'b1;
      end
    end else if (state == S_ZERO && !(j < n) && (i + 5'd1 == n)) begin
      fact_done = 1'b1;
    end
  end

  // Factorization sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      size        <= 5'(chol_pkg::MAX_N);
      last_status <= chol_pkg::STAT_OK;
      i           <= '0;
      j           <= '0;
      k           <= '0;
      sat         <= 1'b0;
    end else begin
      if (matrix_size_we) begin
        size <= matrix_size;
      end
      if (fact_done) begin
        last_status <= fact_status;
        state       <= S_IDLE;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (q_pop && q_item.action == chol_pkg::ACT_FACT) begin
              i     <= '0;
              j     <= '0;
              sat   <= 1'b0;
              state <= S_RD_INIT;
            end
          end
          S_RD_INIT: state <= S_INIT;
          S_INIT: begin
            acc   <= {{(chol_pkg::ACC_W - 48){rd_a[31]}}, rd_a, 16'h0000};
            d     <= rd_b;
            k     <= '0;
            state <= (j == 5'd0) ? S_CLAMP : S_MAC_RD;
          end
          S_MAC_RD:  state <= S_MAC_MUL;
          S_MAC_MUL: begin
            prod  <= $signed(rd_a) * $signed(rd_b);
            state <= S_MAC_ACC;
          end
          S_MAC_ACC: begin
            acc   <= acc - {{(chol_pkg::ACC_W - 64){prod[63]}}, prod};
            k     <= k + 5'd1;
            state <= (k + 5'd1 < j) ? S_MAC_RD : S_CLAMP;
          end
          S_CLAMP: begin
            if (!fits) begin
              sat <= 1'b1;
            end
            state <= S_ITER;
          end
          S_ITER: begin
            if (irsp.done) begin
              res   <= irsp.res;
              sat   <= sat | irsp.sat;
              state <= S_WB;
            end
          end
          S_WB: begin
            if (j < i) begin
              j     <= j + 5'd1;
              state <= S_RD_INIT;
            end else begin
              j     <= i + 5'd1;
              state <= S_ZERO;
            end
          end
          S_ZERO: begin
            if (j < n) begin
              j <= j + 5'd1;
            end else begin
              i     <= i + 5'd1;
              j     <= '0;
              state <= S_RD_INIT;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // Pending result stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        p_valid  <= (q_item.action != chol_pkg::ACT_FACT);
        p_read   <= (q_item.action == chol_pkg::ACT_READ) && q_item.in_range;
        p_status <= last_status;
      end else if (fact_done) begin
        p_valid  <= 1'b1;
        p_read   <= 1'b0;
        p_status <= fact_status;
      end else if (out_load) begin
        p_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= p_valid;
        entry_out    <= p_read ? rd_a : 32'sd0;
        status       <= p_status;
      end
    end
  end

endmodule

### rtl/cholesky_factorizer.sv
// Top level of the Cholesky factorizer: front queue, back end and divide/root unit.
//
// Requests arrive on the item channel (item_valid, item_stall) with fields
// action, row, col and entry_in. Each request yields exactly one result on
// the result channel (result_valid, result_stall) with entry_out and status.
// A write stores entry_in at (row, col); a read returns the stored entry; a
// factorize computes L in place over the n x n matrix set by matrix_size,
// zeroes the upper triangle, and reports ok, not positive definite, or
// saturation. Writes and reads are taken one per cycle from the store while
// the back end is idle and the result is not stalled, and pass through the
// queue, the pending stage and the output register. A factorize is sequenced
// by the back end: each multiply-accumulate term takes a store read, a 32x32
// multiply and a 70-bit accumulate, each off-diagonal entry takes a divide
// and each diagonal entry a square root in the shared iterative unit.
// Reset clears the queue, the result valid flag, the last status and sets n
// to 16; the store itself holds garbage until written. When the receiver
// stalls, the result holds, one more result waits in a pending stage, and
// a two-entry queue keeps taking requests until it fills.
module cholesky_factorizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               matrix_size_we,
  input  logic [4:0]         matrix_size,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         action,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [31:0] entry_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] entry_out,
  output logic [1:0]         status
);

  logic                q_valid;
  logic                q_pop;
  chol_pkg::item_t     q_item;
  chol_pkg::iter_req_t ireq;
  chol_pkg::iter_rsp_t irsp;

  // Front end decodes each request and buffers it.
  chol_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .row        (row),
    .col        (col),
    .entry_in   (entry_in),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Divide and square root share one bit-serial unit.
  chol_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (ireq),
    .rsp (irsp)
  );

  // Back end owns the store, the sequencer and the result register.
  chol_back u_back (
    .clk            (clk),
    .rst            (rst),
    .matrix_size_we (matrix_size_we),
    .matrix_size    (matrix_size),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .ireq           (ireq),
    .irsp           (irsp),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .entry_out      (entry_out),
    .status         (status)
  );

endmodule
